### rtl/ocrw_pkg.sv
// ----------------------------------------------------------------------------
// ocrw_pkg: shared types and constants
// Opcodes, flag positions, masks and the structs passed between the decoder
// core, the window register file and the top level.
// ----------------------------------------------------------------------------
package ocrw_pkg;

	localparam int LINES = 128;
	localparam int PAGES = 16;

	localparam logic [6:0] LINE_MASK = 7'(LINES - 1);
	localparam logic [3:0] PAGE_MASK = 4'(PAGES - 1);

	// command opcodes
	localparam logic [7:0] OP_COL_HI_END   = 8'h18;
	localparam logic [7:0] OP_COL_HI       = 8'h10;
	localparam logic [7:0] OP_PAGE_MODE    = 8'h20;
	localparam logic [7:0] OP_VERT_MODE    = 8'h21;
	localparam logic [7:0] OP_CONTRAST     = 8'h81;
	localparam logic [7:0] OP_REMAP_OFF    = 8'hA0;
	localparam logic [7:0] OP_REMAP_ON     = 8'hA1;
	localparam logic [7:0] OP_ENTIRE_OFF   = 8'hA4;
	localparam logic [7:0] OP_ENTIRE_ON    = 8'hA5;
	localparam logic [7:0] OP_INV_OFF      = 8'hA6;
	localparam logic [7:0] OP_INV_ON       = 8'hA7;
	localparam logic [7:0] OP_MUX_RATIO    = 8'hA8;
	localparam logic [7:0] OP_DISPLAY_OFF  = 8'hAE;
	localparam logic [7:0] OP_DISPLAY_ON   = 8'hAF;
	localparam logic [7:0] OP_SCAN_NORM    = 8'hC0;
	localparam logic [7:0] OP_SCAN_REV     = 8'hC8;
	localparam logic [7:0] OP_DISP_OFFSET  = 8'hD3;
	localparam logic [7:0] OP_CLK_DIV      = 8'hD5;
	localparam logic [7:0] OP_PRECHARGE    = 8'hD9;
	localparam logic [7:0] OP_COM_PINS     = 8'hDA;
	localparam logic [7:0] OP_VCOMH        = 8'hDB;
	localparam logic [7:0] OP_START_LINE_P = 8'hDC;

	localparam logic [6:0] MUX_MIN_EXCL = 7'd14;
	localparam logic [7:0] X_SHIFT      = 8'd96;

	// flag_bits positions
	localparam int FL_REMAP  = 0;
	localparam int FL_ENTIRE = 1;
	localparam int FL_INV    = 2;
	localparam int FL_ON     = 3;
	localparam int FL_SCAN   = 4;

	// configuration register indexes
	localparam logic [2:0] REG_X_OFFSET_ENABLE = 3'd0;
	localparam logic [2:0] REG_PANEL_WIDTH     = 3'd1;
	localparam logic [2:0] REG_COLUMN_START    = 3'd2;
	localparam logic [2:0] REG_COLUMN_END      = 3'd3;
	localparam logic [2:0] REG_PAGE_START      = 3'd4;
	localparam logic [2:0] REG_PAGE_END        = 3'd5;

	typedef struct packed {
		logic       x_offset_enable;
		logic [7:0] panel_width;
		logic [6:0] column_start;
		logic [6:0] column_end;
		logic [3:0] page_start;
		logic [3:0] page_end;
	} cfg_t;

	typedef struct packed {
		logic       ram_write;
		logic [6:0] ram_column;
		logic [3:0] ram_page;
		logic [7:0] ram_data;
		logic       display_on;
		logic       inverse_on;
		logic       entire_on;
		logic       segment_remap;
		logic       scan_reverse;
		logic [6:0] start_line;
		logic [6:0] vertical_offset;
		logic [6:0] mux_ratio;
	} res_t;

endpackage

### rtl/ocrw_cfg.sv
// ----------------------------------------------------------------------------
// ocrw_cfg: configuration register file
// Holds the column remap setup and the address window. The display-off
// command returns the window registers to their reset values.
// ----------------------------------------------------------------------------
module ocrw_cfg
	import ocrw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	input  logic       window_clear,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_offset_enable <= 1'b1;
			cfg_q.panel_width     <= 8'd128;
			cfg_q.column_start    <= 7'd0;
			cfg_q.column_end      <= 7'd127;
			cfg_q.page_start      <= 4'd0;
			cfg_q.page_end        <= 4'd15;
		end else if (window_clear) begin
			cfg_q.column_start <= 7'd0;
			cfg_q.column_end   <= 7'd127;
			cfg_q.page_start   <= 4'd0;
			cfg_q.page_end     <= 4'd15;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_X_OFFSET_ENABLE: cfg_q.x_offset_enable <= wr_data[0];
				REG_PANEL_WIDTH:     cfg_q.panel_width     <= wr_data;
				REG_COLUMN_START:    cfg_q.column_start    <= wr_data[6:0];
				REG_COLUMN_END:      cfg_q.column_end      <= wr_data[6:0];
				REG_PAGE_START:      cfg_q.page_start      <= wr_data[3:0];
				REG_PAGE_END:        cfg_q.page_end        <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		window_clear |=> cfg_q.column_end == 7'd127 && cfg_q.page_end == 4'd15
			&& cfg_q.column_start == 7'd0 && cfg_q.page_start == 4'd0)
		else $error("window not restored after display off");

endmodule

### rtl/ocrw_core.sv
// ----------------------------------------------------------------------------
// ocrw_core: command decoder and address state
// Decodes one byte per step, updates the controller state and forms the
// result beat from the values held after the step; a data write uses the address held before it.
// ----------------------------------------------------------------------------
module ocrw_core
	import ocrw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       action,
	input  logic [7:0] byte_in,
	input  cfg_t       cfg,
	output logic       window_clear,
	output res_t       res
);

	logic [6:0] column_addr_q, column_addr_n;
	logic [3:0] page_addr_q, page_addr_n;
	logic       vertical_mode_q, vertical_mode_n;
	logic [7:0] last_opcode_q, last_opcode_n;
	logic       param_pending_q, param_pending_n;
	logic [6:0] line_start_q, line_start_n;
	logic [6:0] com_offset_q, com_offset_n;
	logic [6:0] mux_value_q, mux_value_n;
	logic [4:0] flag_bits_q, flag_bits_n;

	logic [6:0] mapped_col;
	logic [7:0] col_inc;
	logic [4:0] page_inc;
	logic [6:0] param_val;
	logic       do_clear;

	// column remap: wraps modulo 128, so only the low seven bits matter
	always_comb begin
		if (!cfg.x_offset_enable) begin
			mapped_col = column_addr_q;
		end else if (column_addr_q >= X_SHIFT[6:0]) begin
			mapped_col = column_addr_q - X_SHIFT[6:0];
		end else begin
			mapped_col = 7'({1'b0, column_addr_q} + cfg.panel_width - X_SHIFT);
		end
	end

	assign col_inc   = {1'b0, column_addr_q} + 8'd1;
	assign page_inc  = {1'b0, page_addr_q} + 5'd1;
	assign param_val = byte_in[6:0] & LINE_MASK;

	always_comb begin
		column_addr_n   = column_addr_q;
		page_addr_n     = page_addr_q;
		vertical_mode_n = vertical_mode_q;
		last_opcode_n   = last_opcode_q;
		param_pending_n = param_pending_q;
		line_start_n    = line_start_q;
		com_offset_n    = com_offset_q;
		mux_value_n     = mux_value_q;
		flag_bits_n     = flag_bits_q;
		do_clear        = 1'b0;

		if (action) begin
			if (vertical_mode_q) begin
				page_addr_n = (page_inc > {1'b0, cfg.page_end}) ? cfg.page_start
					: page_inc[3:0];
			end else begin
				column_addr_n = (col_inc > {1'b0, cfg.column_end}) ? cfg.column_start
					: col_inc[6:0];
			end
		end else if (param_pending_q) begin
			param_pending_n = 1'b0;
			unique case (last_opcode_q)
				OP_MUX_RATIO: begin
					if (param_val > MUX_MIN_EXCL) mux_value_n = param_val;
				end
				OP_DISP_OFFSET:  com_offset_n = param_val;
				OP_START_LINE_P: line_start_n = param_val;
				default: ;
			endcase
		end else begin
			last_opcode_n = byte_in;
			priority if (byte_in < OP_COL_HI_END) begin
				if (byte_in < OP_COL_HI) column_addr_n = {column_addr_q[6:4], byte_in[3:0]};
				else                     column_addr_n = {byte_in[2:0], column_addr_q[3:0]};
			end else if (byte_in[7:6] == 2'b01) begin
				line_start_n = byte_in[6:0] & LINE_MASK;
			end else if (byte_in[7:4] == 4'hB) begin
				if (!vertical_mode_q) page_addr_n = byte_in[3:0] & PAGE_MASK;
			end else begin
				unique case (byte_in)
					OP_PAGE_MODE:  vertical_mode_n = 1'b0;
					OP_VERT_MODE:  vertical_mode_n = 1'b1;
					OP_REMAP_OFF:  flag_bits_n[FL_REMAP]  = 1'b0;
					OP_REMAP_ON:   flag_bits_n[FL_REMAP]  = 1'b1;
					OP_ENTIRE_OFF: flag_bits_n[FL_ENTIRE] = 1'b0;
					OP_ENTIRE_ON:  flag_bits_n[FL_ENTIRE] = 1'b1;
					OP_INV_OFF:    flag_bits_n[FL_INV]    = 1'b0;
					OP_INV_ON:     flag_bits_n[FL_INV]    = 1'b1;
					OP_DISPLAY_OFF: begin
						do_clear        = 1'b1;
						column_addr_n   = 7'd0;
						page_addr_n     = 4'd0;
						vertical_mode_n = 1'b0;
						param_pending_n = 1'b0;
						line_start_n    = 7'd0;
						com_offset_n    = 7'd0;
						mux_value_n     = LINE_MASK;
						flag_bits_n     = 5'd0;
					end
					OP_DISPLAY_ON: flag_bits_n[FL_ON]     = 1'b1;
					OP_SCAN_NORM:  flag_bits_n[FL_SCAN]   = 1'b0;
					OP_SCAN_REV:   flag_bits_n[FL_SCAN]   = 1'b1;
					OP_CONTRAST, OP_MUX_RATIO, OP_DISP_OFFSET, OP_CLK_DIV,
					OP_PRECHARGE, OP_COM_PINS, OP_VCOMH, OP_START_LINE_P:
						param_pending_n = 1'b1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_addr_q   <= 7'd0;
			page_addr_q     <= 4'd0;
			vertical_mode_q <= 1'b0;
			last_opcode_q   <= 8'd0;
			param_pending_q <= 1'b0;
			line_start_q    <= 7'd0;
			com_offset_q    <= 7'd0;
			mux_value_q     <= LINE_MASK;
			flag_bits_q     <= 5'd0;
		end else if (step) begin
			column_addr_q   <= column_addr_n;
			page_addr_q     <= page_addr_n;
			vertical_mode_q <= vertical_mode_n;
			last_opcode_q   <= last_opcode_n;
			param_pending_q <= param_pending_n;
			line_start_q    <= line_start_n;
			com_offset_q    <= com_offset_n;
			mux_value_q     <= mux_value_n;
			flag_bits_q     <= flag_bits_n;
		end
	end

	assign window_clear = step & do_clear;

	always_comb begin
		res.ram_write       = action;
		res.ram_column      = action ? mapped_col : 7'd0;
		res.ram_page        = action ? page_addr_q : 4'd0;
		res.ram_data        = action ? byte_in : 8'd0;
		res.display_on      = flag_bits_n[FL_ON];
		res.inverse_on      = flag_bits_n[FL_INV];
		res.entire_on       = flag_bits_n[FL_ENTIRE];
		res.segment_remap   = flag_bits_n[FL_REMAP];
		res.scan_reverse    = flag_bits_n[FL_SCAN];
		res.start_line      = line_start_n;
		res.vertical_offset = com_offset_n;
		res.mux_ratio       = mux_value_n;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step && !action && param_pending_q |=> !param_pending_q)
		else $error("parameter byte left pending flag set");

	assert property (@(posedge clk) disable iff (!arst_n)
		window_clear |=> flag_bits_q == 5'd0 && mux_value_q == LINE_MASK
			&& last_opcode_q == OP_DISPLAY_OFF)
		else $error("display off did not reset state");

	assert property (@(posedge clk) disable iff (!arst_n)
		step && action |=> $stable(param_pending_q) && $stable(flag_bits_q))
		else $error("data beat changed command state");

	assert property (@(posedge clk) disable iff (!arst_n)
		mux_value_q > MUX_MIN_EXCL)
		else $error("mux ratio at or below its minimum");

endmodule

### rtl/oled_command_and_ram_write_decoder.sv
// ----------------------------------------------------------------------------
// oled_command_and_ram_write_decoder: display controller byte decoder
// An accepted input beat goes via the input and result registers to m_*.
// Throughput: one beat per cycle unless m_tready stalls; set by the single
//   decode stage between input and result registers, updating state in one pass.
// Reset (arst_n low): state and window registers return to power-up values,
//   both pipeline stages are emptied. cfg_ready is always high.
// ----------------------------------------------------------------------------
module oled_command_and_ram_write_decoder
	import ocrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tuser,   // [0] action (1 = display data)
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] ram_column, [10:7] ram_page, [18:11] ram_data, [19] display_on,
	// [20] inverse_on, [21] entire_on, [22] segment_remap, [23] scan_reverse,
	// [30:24] start_line, [37:31] vertical_offset, [44:38] mux_ratio, [47:45] zero
	output logic [47:0] m_tdata,
	output logic        m_tuser,   // [0] ram_write
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	res_t       res_s2;

	logic       advance;   // stage 1 may move into the result register
	logic       step;      // a beat is decoded this cycle
	logic       window_clear;
	cfg_t       cfg;
	res_t       res;

	assign advance   = !valid_s2 || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	ocrw_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (cfg_valid && cfg_ready),
		.wr_index     (cfg_index),
		.wr_data      (cfg_data),
		.window_clear (window_clear),
		.cfg          (cfg)
	);

	// decode runs against state that already holds every earlier beat
	ocrw_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.action       (action_s1),
		.byte_in      (byte_s1),
		.cfg          (cfg),
		.window_clear (window_clear),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.ram_write;
	assign m_tdata  = {3'd0, res_s2.mux_ratio, res_s2.vertical_offset, res_s2.start_line,
		res_s2.scan_reverse, res_s2.segment_remap, res_s2.entire_on, res_s2.inverse_on,
		res_s2.display_on, res_s2.ram_data, res_s2.ram_page, res_s2.ram_column};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[18:0] == 19'd0)
		else $error("write fields nonzero on a non-write beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a full pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_tvalid)
		else $error("decoded beat not presented");

endmodule

### tb/oled_command_and_ram_write_decoder_tb.sv
// ----------------------------------------------------------------------------
// oled_command_and_ram_write_decoder_tb: self-checking decoder testbench
// Drives command, parameter and display data bytes into the decoder under
// several window settings. A predictor mirrors the decoder state and checks
// each result beat field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module oled_command_and_ram_write_decoder_tb;
	import ocrw_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 6;
	localparam int IDLE_PCT      = 9;    // idle chance per cycle, in percent
	localparam int SETTLE_CYCLES = 4;    // quiet cycles before a register write
	localparam int TAIL_CYCLES   = 8;    // wait after the last result beat
	localparam int CALM_FIRST    = 400;  // beats sent before idling stops
	localparam int CALM_LAST     = 600;  // beats sent when idling resumes
	localparam int PHASES        = 8;
	localparam int PHASE_BEATS   = 146;

	localparam logic ACT_CMD  = 1'b0;
	localparam logic ACT_DATA = 1'b1;

	// command ranges that the package does not name
	localparam logic [7:0] CMD_LINE_FIRST = 8'h40;
	localparam logic [7:0] CMD_LINE_LAST  = 8'h7F;
	localparam logic [7:0] CMD_PAGE_FIRST = 8'hB0;
	localparam logic [7:0] CMD_PAGE_LAST  = 8'hBF;

	// register indexes past the last window register; writes are dropped
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef enum logic [1:0] {JOB_BYTE, JOB_REG, JOB_DRAIN} job_kind_e;

	typedef struct {
		job_kind_e  kind;
		logic       action;
		logic [2:0] index;
		logic [7:0] value;
	} job_t;

	// DUT ports; all inputs start at known values
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [7:0]  cfg_data  = 8'h00;

	// stimulus and expectations
	job_t        host_jobs[$];
	res_t        expected_decodes[$];
	int unsigned bytes_queued;
	int unsigned bytes_sent;
	int unsigned quiet_cycles;
	int unsigned mismatches;
	logic        calm;

	logic [7:0]  plain_cmds [11];
	logic [7:0]  param_cmds [8];

	// predictor copy of the window registers
	logic        xoff_en;
	logic [7:0]  pnl_width;
	logic [6:0]  col_lo, col_hi;
	logic [3:0]  pg_lo, pg_hi;

	// predictor copy of the decoder state
	logic [6:0]  col_addr;
	logic [3:0]  pg_addr;
	logic        vert_mode;
	logic [7:0]  prev_opcode;
	logic        awaiting_param;
	logic [6:0]  disp_start;
	logic [6:0]  com_shift;
	logic [6:0]  mux_val;
	logic [4:0]  flags;

	assign calm = (bytes_sent >= CALM_FIRST) && (bytes_sent < CALM_LAST);

	always #(CLK_PERIOD / 2) clk = ~clk;

	oled_command_and_ram_write_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	function automatic void clear_window();
		col_lo = 7'd0;
		col_hi = 7'd127;
		pg_lo  = 4'd0;
		pg_hi  = 4'd15;
	endfunction

	function automatic void clear_decoder_state();
		col_addr       = '0;
		pg_addr        = '0;
		vert_mode      = 1'b0;
		prev_opcode    = '0;
		awaiting_param = 1'b0;
		disp_start     = '0;
		com_shift      = '0;
		mux_val        = LINE_MASK;
		flags          = '0;
	endfunction

	// Decodes one byte, updates the mirrored state and returns the result beat.
	function automatic res_t decode_byte(input logic is_data, input logic [7:0] b);
		res_t       r;
		logic [8:0] mapped;
		logic [7:0] next_col;
		logic [4:0] next_pg;
		logic [6:0] prm;
		r   = '0;
		prm = b[6:0] & LINE_MASK;
		if (is_data) begin
			// column remap is modulo 128, so only the low 7 bits matter
			mapped = {2'b00, col_addr};
			if (xoff_en) begin
				if ({1'b0, col_addr} >= X_SHIFT)
					mapped = mapped - {1'b0, X_SHIFT};
				else
					mapped = mapped + {1'b0, pnl_width} - {1'b0, X_SHIFT};
			end
			r.ram_write  = 1'b1;
			r.ram_column = mapped[6:0];
			r.ram_page   = pg_addr;
			r.ram_data   = b;
			// wrap compares the untruncated increment
			if (vert_mode) begin
				next_pg = {1'b0, pg_addr} + 5'd1;
				pg_addr = (next_pg > {1'b0, pg_hi}) ? pg_lo : next_pg[3:0];
			end else begin
				next_col = {1'b0, col_addr} + 8'd1;
				col_addr = (next_col > {1'b0, col_hi}) ? col_lo : next_col[6:0];
			end
		end else if (awaiting_param) begin
			awaiting_param = 1'b0;
			case (prev_opcode)
				OP_MUX_RATIO: begin
					if (prm > MUX_MIN_EXCL) mux_val = prm;
				end
				OP_DISP_OFFSET:  com_shift  = prm;
				OP_START_LINE_P: disp_start = prm;
				default: ;
			endcase
		end else begin
			prev_opcode = b;
			if (b < OP_COL_HI) begin
				col_addr = {col_addr[6:4], b[3:0]};
			end else if (b < OP_COL_HI_END) begin
				col_addr = {b[2:0], col_addr[3:0]};
			end else if (b >= CMD_LINE_FIRST && b <= CMD_LINE_LAST) begin
				disp_start = b[6:0] & LINE_MASK;
			end else if (b >= CMD_PAGE_FIRST && b <= CMD_PAGE_LAST) begin
				if (!vert_mode) pg_addr = b[3:0] & PAGE_MASK;
			end else begin
				case (b)
					OP_PAGE_MODE:   vert_mode = 1'b0;
					OP_VERT_MODE:   vert_mode = 1'b1;
					OP_REMAP_OFF:   flags[FL_REMAP]  = 1'b0;
					OP_REMAP_ON:    flags[FL_REMAP]  = 1'b1;
					OP_ENTIRE_OFF:  flags[FL_ENTIRE] = 1'b0;
					OP_ENTIRE_ON:   flags[FL_ENTIRE] = 1'b1;
					OP_INV_OFF:     flags[FL_INV]    = 1'b0;
					OP_INV_ON:      flags[FL_INV]    = 1'b1;
					OP_DISPLAY_ON:  flags[FL_ON]     = 1'b1;
					OP_SCAN_NORM:   flags[FL_SCAN]   = 1'b0;
					OP_SCAN_REV:    flags[FL_SCAN]   = 1'b1;
					OP_DISPLAY_OFF: begin
						// back to power-up, window included, opcode kept
						clear_decoder_state();
						clear_window();
						prev_opcode = OP_DISPLAY_OFF;
					end
					OP_CONTRAST, OP_MUX_RATIO, OP_DISP_OFFSET, OP_CLK_DIV,
					OP_PRECHARGE, OP_COM_PINS, OP_VCOMH, OP_START_LINE_P:
						awaiting_param = 1'b1;
					default: ;
				endcase
			end
		end
		r.display_on      = flags[FL_ON];
		r.inverse_on      = flags[FL_INV];
		r.entire_on       = flags[FL_ENTIRE];
		r.segment_remap   = flags[FL_REMAP];
		r.scan_reverse    = flags[FL_SCAN];
		r.start_line      = disp_start;
		r.vertical_offset = com_shift;
		r.mux_ratio       = mux_val;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus queue helpers
	// ------------------------------------------------------------------------
	task automatic push_byte(input logic action, input logic [7:0] b);
		job_t j;
		j.kind   = JOB_BYTE;
		j.action = action;
		j.index  = '0;
		j.value  = b;
		host_jobs.push_back(j);
		bytes_queued++;
	endtask

	task automatic push_reg(input logic [2:0] index, input logic [7:0] v);
		job_t j;
		j.kind   = JOB_REG;
		j.action = 1'b0;
		j.index  = index;
		j.value  = v;
		host_jobs.push_back(j);
	endtask

	task automatic push_drain();
		job_t j;
		j.kind   = JOB_DRAIN;
		j.action = 1'b0;
		j.index  = '0;
		j.value  = '0;
		host_jobs.push_back(j);
	endtask

	task automatic write_window(input logic [7:0] xoff, input logic [7:0] width,
			input logic [7:0] cs, input logic [7:0] ce,
			input logic [7:0] ps, input logic [7:0] pe);
		push_reg(REG_X_OFFSET_ENABLE, xoff);
		push_reg(REG_PANEL_WIDTH, width);
		push_reg(REG_COLUMN_START, cs);
		push_reg(REG_COLUMN_END, ce);
		push_reg(REG_PAGE_START, ps);
		push_reg(REG_PAGE_END, pe);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------------
	// driver: input beats and register writes, fed from host_jobs
	// Register writes wait until every result beat is back and a few quiet
	// cycles have passed. A drain job holds the sender until every result beat is back.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : host_driver
		logic       go_s, go_c;
		logic       nxt_act;
		logic [7:0] nxt_byte;
		logic [2:0] nxt_idx;
		logic [7:0] nxt_cfg;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_decodes.push_back(decode_byte(s_tuser, s_tdata));
				bytes_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_OFFSET_ENABLE: xoff_en   = cfg_data[0];
					REG_PANEL_WIDTH:     pnl_width = cfg_data;
					REG_COLUMN_START:    col_lo    = cfg_data[6:0];
					REG_COLUMN_END:      col_hi    = cfg_data[6:0];
					REG_PAGE_START:      pg_lo     = cfg_data[3:0];
					REG_PAGE_END:        pg_hi     = cfg_data[3:0];
					default: ;
				endcase
			end
			// a beat not taken this edge stays on the bus unchanged
			go_s     = s_tvalid && !s_tready;
			go_c     = cfg_valid && !cfg_ready;
			nxt_act  = s_tuser;
			nxt_byte = s_tdata;
			nxt_idx  = cfg_index;
			nxt_cfg  = cfg_data;
			quiet_cycles = (expected_decodes.size() == 0 && !go_s) ? quiet_cycles + 1 : 0;
			if (!go_s && !go_c && host_jobs.size() > 0) begin
				case (host_jobs[0].kind)
					JOB_BYTE: begin
						if (calm || $urandom_range(99) >= IDLE_PCT) begin
							go_s     = 1'b1;
							nxt_act  = host_jobs[0].action;
							nxt_byte = host_jobs[0].value;
							void'(host_jobs.pop_front());
						end
					end
					JOB_REG: begin
						if (quiet_cycles >= SETTLE_CYCLES) begin
							go_c    = 1'b1;
							nxt_idx = host_jobs[0].index;
							nxt_cfg = host_jobs[0].value;
							void'(host_jobs.pop_front());
						end
					end
					default: begin
						if (expected_decodes.size() == 0) void'(host_jobs.pop_front());
					end
				endcase
			end
			s_tvalid  <= go_s;
			s_tuser   <= nxt_act;
			s_tdata   <= nxt_byte;
			cfg_valid <= go_c;
			cfg_index <= nxt_idx;
			cfg_data  <= nxt_cfg;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: random backpressure and field-by-field check of result beats
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		res_t got;
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.ram_write       = m_tuser;
				got.ram_column      = m_tdata[6:0];
				got.ram_page        = m_tdata[10:7];
				got.ram_data        = m_tdata[18:11];
				got.display_on      = m_tdata[19];
				got.inverse_on      = m_tdata[20];
				got.entire_on       = m_tdata[21];
				got.segment_remap   = m_tdata[22];
				got.scan_reverse    = m_tdata[23];
				got.start_line      = m_tdata[30:24];
				got.vertical_offset = m_tdata[37:31];
				got.mux_ratio       = m_tdata[44:38];
				if (expected_decodes.size() == 0) begin
					$error("result beat with no byte outstanding");
					mismatches++;
				end else begin
					want = expected_decodes.pop_front();
					check_field("ram_write", want.ram_write, got.ram_write);
					check_field("ram_column", want.ram_column, got.ram_column);
					check_field("ram_page", want.ram_page, got.ram_page);
					check_field("ram_data", want.ram_data, got.ram_data);
					check_field("display_on", want.display_on, got.display_on);
					check_field("inverse_on", want.inverse_on, got.inverse_on);
					check_field("entire_on", want.entire_on, got.entire_on);
					check_field("segment_remap", want.segment_remap, got.segment_remap);
					check_field("scan_reverse", want.scan_reverse, got.scan_reverse);
					check_field("start_line", want.start_line, got.start_line);
					check_field("vertical_offset", want.vertical_offset,
						got.vertical_offset);
					check_field("mux_ratio", want.mux_ratio, got.mux_ratio);
				end
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned phase_end;
		int unsigned pick;
		logic [7:0]  r;
		plain_cmds = '{OP_PAGE_MODE, OP_VERT_MODE, OP_REMAP_OFF, OP_REMAP_ON,
			OP_ENTIRE_OFF, OP_ENTIRE_ON, OP_INV_OFF, OP_INV_ON, OP_DISPLAY_ON,
			OP_SCAN_NORM, OP_SCAN_REV};
		param_cmds = '{OP_CONTRAST, OP_MUX_RATIO, OP_DISP_OFFSET, OP_CLK_DIV,
			OP_PRECHARGE, OP_COM_PINS, OP_VCOMH, OP_START_LINE_P};

		// power-up values
		xoff_en   = 1'b1;
		pnl_width = 8'd128;
		clear_window();
		clear_decoder_state();

		// directed part, power-up window
		push_byte(ACT_DATA, 8'h00);              // column 0 shifted by the offset
		push_byte(ACT_CMD, OP_DISPLAY_ON);
		push_byte(ACT_CMD, OP_REMAP_ON);
		push_byte(ACT_CMD, OP_ENTIRE_ON);
		push_byte(ACT_CMD, OP_INV_ON);
		push_byte(ACT_CMD, OP_SCAN_REV);
		push_byte(ACT_CMD, 8'h0F);               // column 127
		push_byte(ACT_CMD, 8'h17);
		push_byte(ACT_DATA, 8'hFF);              // top column always wraps
		push_byte(ACT_CMD, CMD_LINE_LAST);
		push_byte(ACT_CMD, OP_VERT_MODE);
		push_byte(ACT_CMD, CMD_PAGE_LAST);       // page select ignored here
		push_byte(ACT_DATA, 8'h5A);
		push_byte(ACT_CMD, OP_PAGE_MODE);
		push_byte(ACT_CMD, CMD_PAGE_LAST);
		push_byte(ACT_DATA, 8'hA5);
		push_byte(ACT_CMD, OP_MUX_RATIO);
		push_byte(ACT_CMD, 8'h0E);               // too small, dropped
		push_byte(ACT_CMD, OP_MUX_RATIO);
		push_byte(ACT_CMD, 8'h8F);               // masked to 15, kept
		push_byte(ACT_CMD, OP_DISP_OFFSET);
		push_byte(ACT_DATA, 8'h3C);              // data leaves parameter armed
		push_byte(ACT_CMD, 8'hFF);
		push_byte(ACT_CMD, OP_START_LINE_P);
		push_byte(ACT_CMD, 8'h80);
		push_byte(ACT_CMD, OP_CONTRAST);
		push_byte(ACT_CMD, OP_DISPLAY_OFF);      // taken as a parameter
		push_byte(ACT_CMD, OP_COL_HI_END);       // unknown opcode
		push_byte(ACT_CMD, OP_DISPLAY_OFF);

		// random phases, each behind a fresh window setting
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_window(8'd0, 8'd96, 8'd0, 8'd127, 8'd0, 8'd15);
				1: write_window(8'd1, 8'd96, 8'd127, 8'd127, 8'd15, 8'd15);
				2: write_window(8'd1, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0);
				3: write_window(8'd1, 8'd255, 8'd100, 8'd20, 8'd12, 8'd3);
				4: begin
					push_reg(REG_SPARE_A, 8'($urandom()));
					push_reg(REG_SPARE_B, 8'($urandom()));
					write_window(8'($urandom()), 8'($urandom()), 8'($urandom()),
						8'($urandom()), 8'($urandom()), 8'($urandom()));
				end
				default: write_window(8'($urandom_range(1)),
					($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(128, 96)),
					8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
			endcase
			phase_end = bytes_queued + PHASE_BEATS;
			while (bytes_queued < phase_end) begin
				pick = $urandom_range(99);
				r    = 8'($urandom());
				if (p == 2 && bytes_queued + PHASE_BEATS / 2 >= phase_end &&
						bytes_queued + PHASE_BEATS / 2 < phase_end + 4)
					push_drain();        // sender waits for every result around mid-phase
				if (pick < 35) begin
					// burst of display data
					repeat ($urandom_range(12, 1)) push_byte(ACT_DATA, 8'($urandom()));
				end else if (pick < 50) begin
					push_byte(ACT_CMD, {4'h0, r[3:0]});
					push_byte(ACT_CMD, OP_COL_HI | {5'd0, r[6:4]});
				end else if (pick < 58) begin
					push_byte(ACT_CMD, CMD_PAGE_FIRST | {4'd0, r[3:0]});
				end else if (pick < 62) begin
					push_byte(ACT_CMD, CMD_LINE_FIRST | {2'd0, r[5:0]});
				end else if (pick < 74) begin
					push_byte(ACT_CMD, param_cmds[$urandom_range(7)]);
					if ($urandom_range(4) == 0) push_byte(ACT_DATA, 8'($urandom()));
					push_byte(ACT_CMD, ($urandom_range(2) == 0) ?
						8'($urandom_range(20)) : r);
				end else if (pick < 90) begin
					push_byte(ACT_CMD, plain_cmds[$urandom_range(10)]);
				end else if (pick < 92 && $urandom_range(1) == 0) begin
					push_byte(ACT_CMD, OP_DISPLAY_OFF);
				end else begin
					// noise: any byte, either kind
					push_byte(1'($urandom()), r);
				end
			end
		end

		// reset once, released on a rising edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (host_jobs.size() != 0 || s_tvalid || cfg_valid ||
				expected_decodes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("** oled_command_and_ram_write_decoder: PASSED **");
		else
			$display("** oled_command_and_ram_write_decoder: FAILED **");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#(CLK_PERIOD * 200000);
		$display("** oled_command_and_ram_write_decoder: FAILED **");
		$finish;
	end

endmodule

### filelist.f
rtl/ocrw_pkg.sv
rtl/ocrw_cfg.sv
rtl/ocrw_core.sv
rtl/oled_command_and_ram_write_decoder.sv
tb/oled_command_and_ram_write_decoder_tb.sv
